@@ sv/assert_macros.svh @@
// Assertion macros for the dispatcher RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge outside reset.
`define TCSD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define TCSD_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/tcsd_pkg.sv @@
// Types and constants of the three-class server dispatcher.
package tcsd_pkg;

	localparam int NUM_CLASSES = 3;
	localparam int CLS_W       = 2;
	localparam int ID_W        = 16;
	localparam int SRV_W       = 3;
	localparam int SCNT_W      = 4;
	localparam int LIM_W       = 3;
	localparam int HCNT_W      = 3;
	localparam int CFG_W       = 4;
	localparam int CFG_IDX_W   = 1;

	localparam logic [HCNT_W-1:0] HCNT_MAX = 3'd7;
	localparam logic [CLS_W-1:0]  CLS_LOW  = 2'd2;
	localparam logic [CLS_W-1:0]  CLS_BAD  = 2'd3;

	localparam logic OP_ARRIVAL = 1'b0;
	localparam logic OP_TICK    = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_SERVER_COUNT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_STARV_LIMIT  = 1'b1;

	localparam logic [SCNT_W-1:0] SERVER_COUNT_RST = 4'd8;
	localparam logic [LIM_W-1:0]  STARV_LIMIT_RST  = 3'd5;

	typedef enum logic [1:0] {
		OUT_GRANT   = 2'd0,
		OUT_QUEUED  = 2'd1,
		OUT_DROPPED = 2'd2,
		OUT_NONE    = 2'd3
	} outcome_t;

	// Control of the queue store port.
	typedef struct packed {
		logic we;
		logic re;
	} mem_ctl_t;

endpackage

@@ sv/tcsd_in_if.sv @@
// Request channel: valid/ready with one arrival or service tick.
interface tcsd_in_if;
	import tcsd_pkg::*;

	logic             valid;
	logic             ready;
	logic             operation;
	logic [CLS_W-1:0] person_class;
	logic [ID_W-1:0]  person_id;

	modport source (output valid, output operation, output person_class, output person_id,
		input ready);
	modport sink (input valid, input operation, input person_class, input person_id,
		output ready);
endinterface

@@ sv/tcsd_out_if.sv @@
// Result channel: valid/ready with one dispatch result.
interface tcsd_out_if;
	import tcsd_pkg::*;

	logic             valid;
	logic             ready;
	logic [1:0]       outcome;
	logic [SRV_W-1:0] server_index;
	logic [ID_W-1:0]  grant_id;
	logic [CLS_W-1:0] grant_class;
	logic             last;

	modport source (output valid, output outcome, output server_index, output grant_id,
		output grant_class, output last, input ready);
	modport sink (input valid, input outcome, input server_index, input grant_id,
		input grant_class, input last, output ready);
endinterface

@@ sv/tcsd_fifo_mem.sv @@
// Single-port store holding the queued ids of all three classes.
module tcsd_fifo_mem #(
	parameter int DEPTH  = 48,
	parameter int ADDR_W = 6
) (
	input  logic                      clk,
	input  tcsd_pkg::mem_ctl_t        ctl,
	input  logic [ADDR_W-1:0]         addr,
	input  logic [tcsd_pkg::ID_W-1:0] wdata,
	output logic [tcsd_pkg::ID_W-1:0] rdata
);
	import tcsd_pkg::*;

	logic [ID_W-1:0] mem_q [DEPTH];
	logic [ID_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem_q[addr] <= wdata;
		end
	end

	// Read data holds until the next read.
	always_ff @(posedge clk) begin
		if (ctl.re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;
endmodule

@@ sv/tcsd_ctrl.sv @@
// Dispatch sequencer: server and queue bookkeeping, tick scan, result register.
`include "assert_macros.svh"
module tcsd_ctrl #(
	parameter int MAX_SERVERS = 8,
	parameter int QUEUE_DEPTH = 16,
	parameter int ADDR_W      = 6
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [tcsd_pkg::SCNT_W-1:0]   server_count,
	input  logic [tcsd_pkg::LIM_W-1:0]    starv_limit,
	tcsd_in_if.sink                       req,
	tcsd_out_if.source                    rsp,
	output tcsd_pkg::mem_ctl_t            mem_ctl,
	output logic [ADDR_W-1:0]             mem_addr,
	output logic [tcsd_pkg::ID_W-1:0]     mem_wdata,
	input  logic [tcsd_pkg::ID_W-1:0]     mem_rdata
);
	import tcsd_pkg::*;

	localparam int SIDX_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
	localparam int PTR_W  = $clog2(QUEUE_DEPTH);
	localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ARR,
		ST_SCAN,
		ST_FIN
	} state_t;

	state_t                  state_q;
	logic [CLS_W-1:0]        cls_q;
	logic [ID_W-1:0]         id_q;
	logic [MAX_SERVERS-1:0]  busy_q;
	logic [PTR_W-1:0]        head_q [NUM_CLASSES];
	logic [CNT_W-1:0]        cnt_q  [NUM_CLASSES];
	logic [HCNT_W-1:0]       hcnt_q;
	logic [CLS_W-1:0]        cidx_q;
	logic                    pend_v_q;
	logic [SRV_W-1:0]        pend_srv_q;
	logic [CLS_W-1:0]        pend_cls_q;

	logic                    out_v_q;
	outcome_t                out_outcome_q;
	logic [SRV_W-1:0]        out_srv_q;
	logic [ID_W-1:0]         out_id_q;
	logic [CLS_W-1:0]        out_cls_q;
	logic                    out_last_q;

	logic                    free_ok;
	logic [SIDX_W-1:0]       free_idx;
	logic [CLS_W-1:0]        ev_cls;
	logic                    blocked;
	logic                    pass;
	logic                    q_empty;
	logic                    q_full;
	logic                    scan_grant;
	logic                    scan_go;
	logic                    arr_go;
	logic                    arr_direct;
	logic                    out_free;
	logic                    out_load;
	logic                    in_xfer;
	logic [PTR_W-1:0]        tail_slot;
	logic [PTR_W-1:0]        head_next;
	logic [HCNT_W-1:0]       hcnt_next;
	logic [CLS_W-1:0]        in_cls;

	function automatic logic [ADDR_W-1:0] slot_addr(input logic [CLS_W-1:0] c,
		input logic [PTR_W-1:0] slot);
		logic [ADDR_W-1:0] base;
		begin
			case (c)
				2'd0:    base = '0;
				2'd1:    base = ADDR_W'(QUEUE_DEPTH);
				default: base = ADDR_W'(2 * QUEUE_DEPTH);
			endcase
			slot_addr = base + ADDR_W'(slot);
		end
	endfunction

	// Lowest free server within the active range.
	always_comb begin
		free_ok  = 1'b0;
		free_idx = '0;
		for (int i = MAX_SERVERS - 1; i >= 0; i--) begin
			if ((SCNT_W'(i) < server_count) && !busy_q[i]) begin
				free_ok  = 1'b1;
				free_idx = SIDX_W'(i);
			end
		end
	end

	always_comb begin
		logic [PTR_W:0] sum;
		logic [PTR_W:0] hinc;
		ev_cls  = (state_q == ST_SCAN) ? cidx_q : cls_q;
		blocked = (hcnt_q >= starv_limit) && (ev_cls != CLS_LOW) && (cnt_q[2] != '0);
		pass    = free_ok && !blocked;
		q_empty = (cnt_q[ev_cls] == '0);
		q_full  = (cnt_q[ev_cls] >= CNT_W'(QUEUE_DEPTH));

		sum = (PTR_W+1)'(head_q[ev_cls]) + (PTR_W+1)'(cnt_q[ev_cls]);
		if (sum >= (PTR_W+1)'(QUEUE_DEPTH)) begin
			sum = sum - (PTR_W+1)'(QUEUE_DEPTH);
		end
		tail_slot = sum[PTR_W-1:0];

		hinc = (PTR_W+1)'(head_q[ev_cls]) + 1'b1;
		head_next = (hinc == (PTR_W+1)'(QUEUE_DEPTH)) ? '0 : hinc[PTR_W-1:0];

		if (ev_cls == CLS_LOW) begin
			hcnt_next = '0;
		end else if (hcnt_q < HCNT_MAX) begin
			hcnt_next = hcnt_q + 1'b1;
		end else begin
			hcnt_next = hcnt_q;
		end
	end

	assign out_free   = !out_v_q || rsp.ready;
	assign in_xfer    = req.valid && req.ready;
	assign in_cls     = (req.person_class == CLS_BAD) ? CLS_LOW : req.person_class;
	assign arr_go     = (state_q == ST_ARR) && out_free;
	assign arr_direct = q_empty && pass;
	assign scan_grant = (state_q == ST_SCAN) && !q_empty && pass;
	// A new grant may need the held one pushed out first.
	assign scan_go    = scan_grant && (!pend_v_q || out_free);
	// Result register takes a new result this cycle.
	assign out_load   = arr_go || (scan_go && pend_v_q) || ((state_q == ST_FIN) && out_free);

	assign mem_ctl.we = arr_go && !arr_direct && !q_full;
	assign mem_ctl.re = scan_go;
	assign mem_addr   = slot_addr(ev_cls, (state_q == ST_SCAN) ? head_q[ev_cls] : tail_slot);
	assign mem_wdata  = id_q;

	assign req.ready        = (state_q == ST_IDLE);
	assign rsp.valid        = out_v_q;
	assign rsp.outcome      = out_outcome_q;
	assign rsp.server_index = out_srv_q;
	assign rsp.grant_id     = out_id_q;
	assign rsp.grant_class  = out_cls_q;
	assign rsp.last         = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			cls_q         <= '0;
			id_q          <= '0;
			busy_q        <= '0;
			for (int c = 0; c < NUM_CLASSES; c++) begin
				head_q[c] <= '0;
				cnt_q[c]  <= '0;
			end
			hcnt_q        <= '0;
			cidx_q        <= '0;
			pend_v_q      <= 1'b0;
			pend_srv_q    <= '0;
			pend_cls_q    <= '0;
			out_v_q       <= 1'b0;
			out_outcome_q <= OUT_NONE;
			out_srv_q     <= '0;
			out_id_q      <= '0;
			out_cls_q     <= '0;
			out_last_q    <= 1'b0;
		end else begin
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (out_v_q && rsp.ready) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						cls_q  <= in_cls;
						id_q   <= req.person_id;
						cidx_q <= '0;
						if (req.operation == OP_TICK) begin
							busy_q  <= '0;
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_ARR;
						end
					end
				end
				ST_ARR: begin
					if (out_free) begin
						out_id_q   <= id_q;
						out_cls_q  <= cls_q;
						out_last_q <= 1'b1;
						if (arr_direct) begin
							busy_q[free_idx] <= 1'b1;
							hcnt_q           <= hcnt_next;
							out_outcome_q    <= OUT_GRANT;
							out_srv_q        <= SRV_W'(free_idx);
						end else if (q_full) begin
							out_outcome_q <= OUT_DROPPED;
							out_srv_q     <= '0;
						end else begin
							cnt_q[cls_q]  <= cnt_q[cls_q] + 1'b1;
							out_outcome_q <= OUT_QUEUED;
							out_srv_q     <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				ST_SCAN: begin
					if (scan_go) begin
						if (pend_v_q) begin
							out_outcome_q <= OUT_GRANT;
							out_srv_q     <= pend_srv_q;
							out_id_q      <= mem_rdata;
							out_cls_q     <= pend_cls_q;
							out_last_q    <= 1'b0;
						end
						busy_q[free_idx] <= 1'b1;
						hcnt_q           <= hcnt_next;
						head_q[cidx_q]   <= head_next;
						cnt_q[cidx_q]    <= cnt_q[cidx_q] - 1'b1;
						pend_v_q         <= 1'b1;
						pend_srv_q       <= SRV_W'(free_idx);
						pend_cls_q       <= cidx_q;
					end
					if (scan_go || !scan_grant) begin
						if (cidx_q == CLS_LOW) begin
							state_q <= ST_FIN;
						end else begin
							cidx_q <= cidx_q + 1'b1;
						end
					end
				end
				ST_FIN: begin
					if (out_free) begin
						out_last_q <= 1'b1;
						if (pend_v_q) begin
							out_outcome_q <= OUT_GRANT;
							out_srv_q     <= pend_srv_q;
							out_id_q      <= mem_rdata;
							out_cls_q     <= pend_cls_q;
						end else begin
							out_outcome_q <= OUT_NONE;
							out_srv_q     <= '0;
							out_id_q      <= '0;
							out_cls_q     <= '0;
						end
						pend_v_q <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`TCSD_ASSERT_ALWAYS(a_mem_port_excl, !(mem_ctl.we && mem_ctl.re), "store read and write collide")
	`TCSD_ASSERT(a_tick_frees, (in_xfer && req.operation == OP_TICK) |=> (busy_q == '0), "tick left a server busy")
	`TCSD_ASSERT(a_arr_result, (state_q == ST_ARR && out_free) |=> (rsp.valid && rsp.last && state_q == ST_IDLE), "arrival result missing")
	`TCSD_ASSERT(a_fin_result, (state_q == ST_FIN && out_free) |=> (rsp.valid && rsp.last), "tick final result missing")
endmodule

@@ sv/three_class_server_dispatch.sv @@
// Top level of the three-class server dispatcher.
// Usage:
//   req channel (valid/ready): operation 0 is an arrival of person_id in
//   person_class, operation 1 is a service tick that frees all servers and
//   tries each class queue head once in class order.
//   rsp channel (valid/ready): one result per arrival; one result per grant
//   of a tick (up to three), or one no-grant result; last marks the final one.
//   cfg port: cfg_we/cfg_index/cfg_wdata, index 0 server_count, 1 starvation
//   limit; write only while the block is idle.
// Timing: one item at a time. An arrival passes from transfer through the
//   arrival step to the result register; a tick runs one sequencer step per
//   class (a step can wait on a stalled rsp), then the final step, which
//   registers the last result; the scan goes through the single-port id store.
//   The next request is taken as soon as the last result is registered.
// Reset: servers free, queues empty, grant count zero, server_count 8,
//   starvation limit 5; the id store needs no clearing.
// Stall: while rsp is not ready the result register holds and the sequencer
//   waits at its next result.
module three_class_server_dispatch #(
	parameter int MAX_SERVERS = 8,
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	tcsd_in_if.sink                        req,
	tcsd_out_if.source                     rsp,
	input  logic                           cfg_we,
	input  logic [tcsd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tcsd_pkg::CFG_W-1:0]     cfg_wdata
);
	import tcsd_pkg::*;

	localparam int MEM_DEPTH = NUM_CLASSES * QUEUE_DEPTH;
	localparam int ADDR_W    = $clog2(MEM_DEPTH);

	logic [SCNT_W-1:0] server_count_q;
	logic [LIM_W-1:0]  starv_limit_q;
	mem_ctl_t          mem_ctl;
	logic [ADDR_W-1:0] mem_addr;
	logic [ID_W-1:0]   mem_wdata;
	logic [ID_W-1:0]   mem_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			server_count_q <= SERVER_COUNT_RST;
			starv_limit_q  <= STARV_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SERVER_COUNT: server_count_q <= cfg_wdata;
				CFG_STARV_LIMIT:  starv_limit_q  <= cfg_wdata[LIM_W-1:0];
				default: begin
				end
			endcase
		end
	end

	tcsd_ctrl #(
		.MAX_SERVERS (MAX_SERVERS),
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.ADDR_W      (ADDR_W)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.server_count (server_count_q),
		.starv_limit  (starv_limit_q),
		.req          (req),
		.rsp          (rsp),
		.mem_ctl      (mem_ctl),
		.mem_addr     (mem_addr),
		.mem_wdata    (mem_wdata),
		.mem_rdata    (mem_rdata)
	);

	tcsd_fifo_mem #(
		.DEPTH  (MEM_DEPTH),
		.ADDR_W (ADDR_W)
	) u_mem (
		.clk   (clk),
		.ctl   (mem_ctl),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);
endmodule
